// ===== hdl/psq_pkg.sv =====
// ---------------------------------------------------------------------------
// psq_pkg
// Shared types, codes and sizes for the priority quantum scheduler.
// ---------------------------------------------------------------------------
package psq_pkg;

  // table and arithmetic sizes
  localparam int SLOT_COUNT  = 16;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int SLOT_PORT_W = 4;
  localparam int FRAC_BITS   = 16;
  localparam int PRIO_W      = FRAC_BITS + 1;
  localparam int OP_W        = 3;
  localparam int QT_W        = 8;
  localparam int STATUS_W    = 2;
  localparam int DIV_W       = QT_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  localparam logic [QT_W-1:0] QUANTUM_RESET = QT_W'(50);

  // event codes
  localparam logic [OP_W-1:0] OP_TICK   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_CREATE = OP_W'(1);
  localparam logic [OP_W-1:0] OP_BLOCK  = OP_W'(2);
  localparam logic [OP_W-1:0] OP_WAKE   = OP_W'(3);
  localparam logic [OP_W-1:0] OP_KILL   = OP_W'(4);

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = STATUS_W'(2);

  // slot states
  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_READY = 2'd1,
    ST_RUN   = 2'd2,
    ST_BLOCK = 2'd3
  } slot_state_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE_SCAN,
    S_APPLY,
    S_CHECK,
    S_DIVIDE,
    S_UPDATE,
    S_READY_SCAN,
    S_DISPATCH,
    S_RESULT
  } psq_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic free_scan;
    logic apply;
    logic div_load;
    logic div_step;
    logic update;
    logic ready_scan;
    logic dispatch;
    logic load_out;
  } psq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_create;
    logic scan_last;
    logic run_ok;
    logic expired;
    logic div_last;
    logic out_busy;
  } psq_stat_t;

endpackage

// ===== hdl/psq_ctrl.sv =====
// ---------------------------------------------------------------------------
// psq_ctrl
// Sequencer for one event: free scan, event update, expiry division,
// ready scan, dispatch and result hand-off.
// ---------------------------------------------------------------------------
module psq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  psq_pkg::psq_stat_t  stat,
  output psq_pkg::psq_cmd_t   cmd
);

  psq_pkg::psq_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      psq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          // a create first looks for the lowest free slot
          if (stat.is_create) begin
            state_next = psq_pkg::S_FREE_SCAN;
          end else begin
            state_next = psq_pkg::S_APPLY;
          end
        end
      end
      psq_pkg::S_FREE_SCAN: begin
        cmd.free_scan = 1'b1;
        if (stat.scan_last) begin
          state_next = psq_pkg::S_APPLY;
        end
      end
      psq_pkg::S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = psq_pkg::S_CHECK;
      end
      psq_pkg::S_CHECK: begin
        if (!stat.run_ok) begin
          state_next = psq_pkg::S_READY_SCAN;
        end else if (stat.expired) begin
          cmd.div_load = 1'b1;
          state_next   = psq_pkg::S_DIVIDE;
        end else begin
          state_next = psq_pkg::S_RESULT;
        end
      end
      psq_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = psq_pkg::S_UPDATE;
        end
      end
      psq_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = psq_pkg::S_READY_SCAN;
      end
      psq_pkg::S_READY_SCAN: begin
        cmd.ready_scan = 1'b1;
        if (stat.scan_last) begin
          state_next = psq_pkg::S_DISPATCH;
        end
      end
      psq_pkg::S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        state_next   = psq_pkg::S_RESULT;
      end
      psq_pkg::S_RESULT: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = psq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = psq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/psq_dp.sv =====
// ---------------------------------------------------------------------------
// psq_dp
// Slot table, quantum counter, serial priority divider, scan unit and
// result register of the scheduler.
// ---------------------------------------------------------------------------
module psq_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  psq_pkg::psq_cmd_t                   cmd,
  output psq_pkg::psq_stat_t                  stat,
  input  logic [psq_pkg::OP_W-1:0]            operation,
  input  logic [psq_pkg::SLOT_PORT_W-1:0]     slot_index,
  input  logic                                cfg_valid,
  input  logic [psq_pkg::QT_W-1:0]            cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                running_valid,
  output logic [psq_pkg::SLOT_PORT_W-1:0]     running_slot,
  output logic                                switched,
  output logic [psq_pkg::SLOT_PORT_W-1:0]     preempted_slot,
  output logic [psq_pkg::QT_W-1:0]            used_ticks,
  output logic [psq_pkg::SLOT_PORT_W-1:0]     created_slot,
  output logic [psq_pkg::STATUS_W-1:0]        status
);

  localparam int SW = psq_pkg::SLOT_W;
  localparam int PW = psq_pkg::PRIO_W;
  localparam int QW = psq_pkg::QT_W;
  localparam int DW = psq_pkg::DIV_W;
  localparam int CW = psq_pkg::DIV_CNT_W;

  // slot table
  psq_pkg::slot_state_t  st   [psq_pkg::SLOT_COUNT];
  logic [PW-1:0]         prio [psq_pkg::SLOT_COUNT];

  // scheduler state
  logic [SW-1:0]  cur;
  logic           cv;
  logic [QW-1:0]  qleft;
  logic [QW-1:0]  qt;

  // latched event
  logic [psq_pkg::OP_W-1:0]        op_r;
  logic [psq_pkg::SLOT_PORT_W-1:0] tgt_r;

  // scan unit
  logic [SW-1:0]  idx;
  logic           free_found;
  logic [SW-1:0]  free_best;
  logic           rdy_found;
  logic [SW-1:0]  rdy_best;
  logic [PW-1:0]  rdy_prio;

  // per-event result
  logic [psq_pkg::STATUS_W-1:0] status_r;
  logic [SW-1:0]                created_r;
  logic                         sw_r;
  logic [SW-1:0]                pre_r;
  logic [QW-1:0]                used_r;

  // divider
  logic [DW-1:0]  num;
  logic [QW-1:0]  rem;
  logic [PW-1:0]  quo;
  logic [CW-1:0]  cnt;

  // combinational helpers
  logic [SW-1:0]         rd_addr;
  psq_pkg::slot_state_t  rd_state;
  logic [PW-1:0]         rd_prio;
  logic [QW-1:0]         effq;
  logic [QW-1:0]         used_now;
  logic                  tgt_ok;
  logic                  tgt_op;
  logic [QW:0]           r2;
  logic                  ge;
  logic [PW:0]           psum;

  // single table read port
  always_comb begin
    tgt_op = (op_r == psq_pkg::OP_WAKE) || (op_r == psq_pkg::OP_KILL);
    priority if (cmd.free_scan || cmd.ready_scan) begin
      rd_addr = idx;
    end else if (cmd.apply && tgt_op) begin
      rd_addr = SW'(tgt_r);
    end else begin
      rd_addr = cur;
    end
    rd_state = st[rd_addr];
    rd_prio  = prio[rd_addr];
  end

  // quantum arithmetic, zero quantum acts as one
  assign effq     = (qt == '0) ? QW'(1) : qt;
  assign used_now = (qleft > effq) ? '0 : QW'(effq - qleft);
  assign tgt_ok   = (32'(tgt_r) < 32'(psq_pkg::SLOT_COUNT));

  // restoring division step
  assign r2   = {rem, num[DW-1]};
  assign ge   = (r2 >= {1'b0, effq});
  assign psum = {1'b0, rd_prio} + {1'b0, quo};

  // status to controller
  always_comb begin
    stat.is_create = cmd.latch ? (operation == psq_pkg::OP_CREATE)
                               : (op_r == psq_pkg::OP_CREATE);
    stat.scan_last = (idx == SW'(psq_pkg::SLOT_COUNT - 1));
    stat.run_ok    = cv && (rd_state == psq_pkg::ST_RUN);
    stat.expired   = (qleft == '0);
    stat.div_last  = (cnt == CW'(DW - 1));
    stat.out_busy  = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv        <= 1'b0;
      cur       <= '0;
      qleft     <= psq_pkg::QUANTUM_RESET;
      qt        <= psq_pkg::QUANTUM_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < psq_pkg::SLOT_COUNT; i++) begin
        st[i]   <= psq_pkg::ST_FREE;
        prio[i] <= '0;
      end
    end else begin
      // configuration word
      if (cfg_valid) begin
        qt <= cfg_data;
      end

      // result word loaded or taken
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // latch event
      if (cmd.latch) begin
        op_r       <= operation;
        tgt_r      <= slot_index;
        idx        <= '0;
        free_found <= 1'b0;
        free_best  <= '0;
        rdy_found  <= 1'b0;
        rdy_best   <= '0;
        rdy_prio   <= '0;
        status_r   <= psq_pkg::STATUS_OK;
        created_r  <= '0;
        sw_r       <= 1'b0;
        pre_r      <= '0;
        used_r     <= '0;
      end

      // lowest free slot
      if (cmd.free_scan) begin
        if (!free_found && rd_state == psq_pkg::ST_FREE) begin
          free_found <= 1'b1;
          free_best  <= idx;
        end
        idx <= stat.scan_last ? '0 : SW'(idx + 1'b1);
      end

      // event update
      if (cmd.apply) begin
        unique case (op_r)
          psq_pkg::OP_TICK: begin
            if (cv && qleft != '0) begin
              qleft <= QW'(qleft - 1'b1);
            end
          end
          psq_pkg::OP_CREATE: begin
            if (free_found) begin
              st[free_best]   <= psq_pkg::ST_READY;
              prio[free_best] <= '0;
              created_r       <= free_best;
            end else begin
              status_r <= psq_pkg::STATUS_NO_FREE;
            end
          end
          psq_pkg::OP_BLOCK: begin
            if (cv && rd_state == psq_pkg::ST_RUN) begin
              st[cur] <= psq_pkg::ST_BLOCK;
            end else begin
              status_r <= psq_pkg::STATUS_BAD_SLOT;
            end
          end
          psq_pkg::OP_WAKE: begin
            if (tgt_ok && rd_state == psq_pkg::ST_BLOCK) begin
              st[rd_addr] <= psq_pkg::ST_READY;
            end else begin
              status_r <= psq_pkg::STATUS_BAD_SLOT;
            end
          end
          psq_pkg::OP_KILL: begin
            if (tgt_ok && rd_state != psq_pkg::ST_FREE) begin
              st[rd_addr] <= psq_pkg::ST_FREE;
              // only the killed current slot loses the processor
              if (cv && cur == rd_addr) begin
                cv <= 1'b0;
              end
            end else begin
              status_r <= psq_pkg::STATUS_BAD_SLOT;
            end
          end
          default: begin
          end
        endcase
      end

      // divider start: used ticks in Q.FRAC_BITS
      if (cmd.div_load) begin
        num <= {used_now, psq_pkg::FRAC_BITS'(0)};
        rem <= '0;
        quo <= '0;
        cnt <= '0;
      end

      // one quotient bit a cycle
      if (cmd.div_step) begin
        num <= {num[DW-2:0], 1'b0};
        rem <= ge ? QW'(r2 - {1'b0, effq}) : QW'(r2);
        quo <= {quo[PW-2:0], ge};
        cnt <= CW'(cnt + 1'b1);
      end

      // expired slot: average priority and back to ready
      if (cmd.update) begin
        prio[cur] <= psum[PW:1];
        st[cur]   <= psq_pkg::ST_READY;
      end

      // lowest priority ready slot, first index on ties
      if (cmd.ready_scan) begin
        if (rd_state == psq_pkg::ST_READY && (!rdy_found || rd_prio < rdy_prio)) begin
          rdy_found <= 1'b1;
          rdy_best  <= idx;
          rdy_prio  <= rd_prio;
        end
        idx <= stat.scan_last ? '0 : SW'(idx + 1'b1);
      end

      // dispatch
      if (cmd.dispatch) begin
        if (rdy_found) begin
          st[rdy_best] <= psq_pkg::ST_RUN;
          if (cv && cur != rdy_best) begin
            sw_r   <= 1'b1;
            pre_r  <= cur;
            used_r <= used_now;
          end
          cur   <= rdy_best;
          cv    <= 1'b1;
          qleft <= effq;
        end else begin
          cv <= 1'b0;
        end
      end

      // result word
      if (cmd.load_out) begin
        running_valid  <= cv;
        running_slot   <= cv ? psq_pkg::SLOT_PORT_W'(cur) : '0;
        switched       <= sw_r;
        preempted_slot <= psq_pkg::SLOT_PORT_W'(pre_r);
        used_ticks     <= used_r;
        created_slot   <= psq_pkg::SLOT_PORT_W'(created_r);
        status         <= status_r;
      end
    end
  end

endmodule

// ===== hdl/priority_quantum_scheduler.sv =====
// Each event is latched, applied and checked before its result word is loaded; a create first
// runs a free scan, a reschedule adds a ready scan and dispatch, and an expiring quantum adds
// a serial divide and priority update ahead of the ready scan.
// One event at a time: the next is taken only once the result word has been loaded;
// a held result word stalls hand-off.
// Synchronous reset: all slots free, priorities zero, nothing running, quantum 50.
// ---------------------------------------------------------------------------
// priority_quantum_scheduler
// Process-slot scheduler with quantum counting and averaged priorities.
// ---------------------------------------------------------------------------
module priority_quantum_scheduler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [psq_pkg::OP_W-1:0]            operation,
  input  logic [psq_pkg::SLOT_PORT_W-1:0]     slot_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                running_valid,
  output logic [psq_pkg::SLOT_PORT_W-1:0]     running_slot,
  output logic                                switched,
  output logic [psq_pkg::SLOT_PORT_W-1:0]     preempted_slot,
  output logic [psq_pkg::QT_W-1:0]            used_ticks,
  output logic [psq_pkg::SLOT_PORT_W-1:0]     created_slot,
  output logic [psq_pkg::STATUS_W-1:0]        status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psq_pkg::QT_W-1:0]            cfg_data
);

  psq_pkg::psq_cmd_t  cmd;
  psq_pkg::psq_stat_t stat;

  // configuration word always taken
  assign cfg_ready = 1'b1;

  // controller
  psq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  psq_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .operation      (operation),
    .slot_index     (slot_index),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .running_valid  (running_valid),
    .running_slot   (running_slot),
    .switched       (switched),
    .preempted_slot (preempted_slot),
    .used_ticks     (used_ticks),
    .created_slot   (created_slot),
    .status         (status)
  );

endmodule

// ===== hdl/psq_checker.sv =====
// ---------------------------------------------------------------------------
// psq_checker
// Port-level checks of the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
module psq_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                running_valid,
  input  logic [psq_pkg::SLOT_PORT_W-1:0]     running_slot,
  input  logic                                switched,
  input  logic [psq_pkg::SLOT_PORT_W-1:0]     preempted_slot,
  input  logic [psq_pkg::QT_W-1:0]            used_ticks,
  input  logic [psq_pkg::SLOT_PORT_W-1:0]     created_slot,
  input  logic [psq_pkg::STATUS_W-1:0]        status
);

  // a switch always lands on a different running slot
  a_switch_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && switched |-> running_valid && running_slot != preempted_slot)
    else $error("switch without a new running slot");

  // no switch, no preempted slot or used ticks
  a_switch_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !switched |-> preempted_slot == '0 && used_ticks == '0)
    else $error("switch fields set without a switch");

  // one event in flight: ready drops after an accept
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second event accepted while busy");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(running_slot) && $stable(status)
      && $stable(created_slot) && $stable(switched))
    else $error("result word changed while stalled");

endmodule

bind priority_quantum_scheduler psq_checker u_psq_checker (.*);
